FILE: src/clnfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnfs_pkg
// Types, constants, init table and microcode ROM for the character-LCD
// nibble frame sequencer.
// ----------------------------------------------------------------------------
package clnfs_pkg;

    // Request kinds
    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;
    localparam logic [1:0] KIND_PRINT  = 2'd3;

    // Field widths
    localparam int NUM_W      = 31;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(NUM_W);

    // Frame bits
    localparam logic [7:0] EN_BIT     = 8'h04;
    localparam logic [7:0] BL_BIT     = 8'h08;
    localparam logic [7:0] CURSOR_CMD = 8'h80;
    localparam logic [7:0] ROW1_ADDR  = 8'h40;
    localparam logic [3:0] ASCII_HI   = 4'h3;

    // Init table
    localparam int INIT_LEN   = 42;
    localparam int TBL_IDX_W  = $clog2(INIT_LEN);
    localparam logic [7:0] INIT_TABLE [INIT_LEN] = '{
        8'h30, 8'h34, 8'h30, 8'h30, 8'h34, 8'h30, 8'h30, 8'h34, 8'h30,
        8'h20, 8'h24, 8'h20, 8'h20, 8'h24, 8'h20, 8'h80, 8'h84, 8'h80,
        8'h00, 8'h04, 8'h00, 8'hc0, 8'hc4, 8'hc0, 8'h00, 8'h04, 8'h00,
        8'h10, 8'h14, 8'h10, 8'h00, 8'h04, 8'h00, 8'h60, 8'h64, 8'h60,
        8'h00, 8'h04, 8'h00, 8'h20, 8'h24, 8'h20
    };

    // Payload types
    typedef struct packed {
        logic [1:0]       kind;
        logic             is_data;
        logic [7:0]       byte_value;
        logic [3:0]       column;
        logic             row;
        logic [NUM_W-1:0] number;
    } in_item_t;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last;
    } out_item_t;

    // Control between sequencer and digit unit
    typedef struct packed {
        logic load;
        logic conv;
        logic align;
        logic skip;
        logic pop;
        logic dec;
    } digit_ctrl_t;

    typedef struct packed {
        logic [3:0] top_digit;
        logic       conv_done;
        logic       skip_more;
        logic       cnt_one;
    } digit_stat_t;

    // Microcode fields
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD_WR,
        OP_LOAD_CUR,
        OP_CONV_LOAD,
        OP_CONV,
        OP_ALIGN,
        OP_SKIP,
        OP_LOAD_DIG,
        OP_EMIT,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        FR_HI,
        FR_HI_EN,
        FR_LO,
        FR_LO_EN,
        FR_ZERO,
        FR_TABLE
    } frame_t;

    typedef enum logic [1:0] {
        L_NO,
        L_YES,
        L_TABLE,
        L_DIGIT
    } last_t;

    typedef enum logic [1:0] {
        J_NEVER,
        J_ALWAYS,
        J_MORE_DIGITS
    } jump_t;

    localparam int PC_W = 5;

    typedef struct packed {
        op_t             op;
        frame_t          frame;
        last_t           last_sel;
        jump_t           jump;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Program entry points
    localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
    localparam logic [PC_W-1:0] PC_INIT      = 5'd1;
    localparam logic [PC_W-1:0] PC_WRITE     = 5'd3;
    localparam logic [PC_W-1:0] PC_BYTE      = 5'd4;
    localparam logic [PC_W-1:0] PC_CURSOR    = 5'd9;
    localparam logic [PC_W-1:0] PC_PRINT     = 5'd10;
    localparam logic [PC_W-1:0] PC_DIGIT     = 5'd14;

    // Microcode ROM
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, frame: FR_ZERO, last_sel: L_NO, jump: J_ALWAYS, target: PC_IDLE};
        unique case (pc)
            5'd0:  w = '{OP_IDLE,      FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            // init: zero frame, then the table
            5'd1:  w = '{OP_EMIT,      FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd2:  w = '{OP_EMIT,      FR_TABLE, L_TABLE, J_ALWAYS,      PC_IDLE};
            // write byte, shared five-frame tail also used by cursor
            5'd3:  w = '{OP_LOAD_WR,   FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd4:  w = '{OP_EMIT,      FR_HI,    L_NO,    J_NEVER,       PC_IDLE};
            5'd5:  w = '{OP_EMIT,      FR_HI_EN, L_NO,    J_NEVER,       PC_IDLE};
            5'd6:  w = '{OP_EMIT,      FR_LO,    L_NO,    J_NEVER,       PC_IDLE};
            5'd7:  w = '{OP_EMIT,      FR_LO_EN, L_NO,    J_NEVER,       PC_IDLE};
            5'd8:  w = '{OP_EMIT,      FR_LO,    L_YES,   J_ALWAYS,      PC_IDLE};
            // set cursor
            5'd9:  w = '{OP_LOAD_CUR,  FR_ZERO,  L_NO,    J_ALWAYS,      PC_BYTE};
            // print integer
            5'd10: w = '{OP_CONV_LOAD, FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd11: w = '{OP_CONV,      FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd12: w = '{OP_ALIGN,     FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd13: w = '{OP_SKIP,      FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd14: w = '{OP_LOAD_DIG,  FR_ZERO,  L_NO,    J_NEVER,       PC_IDLE};
            5'd15: w = '{OP_EMIT,      FR_HI,    L_NO,    J_NEVER,       PC_IDLE};
            5'd16: w = '{OP_EMIT,      FR_HI_EN, L_NO,    J_NEVER,       PC_IDLE};
            5'd17: w = '{OP_EMIT,      FR_LO,    L_NO,    J_NEVER,       PC_IDLE};
            5'd18: w = '{OP_EMIT,      FR_LO_EN, L_NO,    J_NEVER,       PC_IDLE};
            5'd19: w = '{OP_EMIT,      FR_LO,    L_DIGIT, J_MORE_DIGITS, PC_DIGIT};
            5'd20: w = '{OP_NOP,       FR_ZERO,  L_NO,    J_ALWAYS,      PC_IDLE};
            default: w = '{OP_NOP,     FR_ZERO,  L_NO,    J_ALWAYS,      PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/clnfs_digit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnfs_digit_unit
// Binary to decimal conversion by shift-and-add-3, one bit per cycle, and a
// digit window that drops leading zeros and hands out digits most
// significant first.
// ----------------------------------------------------------------------------
module clnfs_digit_unit #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  clnfs_pkg::digit_ctrl_t     ctrl,
    input  logic [clnfs_pkg::NUM_W-1:0] number,
    output clnfs_pkg::digit_stat_t     stat
);
    import clnfs_pkg::*;

    localparam int WIN_W = MAX_DIGITS * 4;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 above_reg, above_next;
    logic [3:0]           top_digit;
    logic                 skip_more;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    assign top_digit = win_reg[WIN_W-1 -: 4];
    assign skip_more = (cnt_reg > CNT_W'(1)) && (top_digit == 4'd0) && !above_reg;

    // Next state of the conversion and digit window
    always_comb begin
        num_next     = num_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        win_next     = win_reg;
        cnt_next     = cnt_reg;
        above_next   = above_reg;
        if (ctrl.load) begin
            num_next     = number;
            bcd_next     = '0;
            bit_cnt_next = '0;
        end
        if (ctrl.conv) begin
            num_next     = num_reg << 1;
            bcd_next     = {bcd_adj[BCD_W-2:0], num_reg[NUM_W-1]};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end
        if (ctrl.align) begin
            win_next   = bcd_reg[WIN_W-1:0];
            cnt_next   = CNT_W'(MAX_DIGITS);
            above_next = |(bcd_reg >> WIN_W);
        end
        if (ctrl.skip && skip_more) begin
            win_next = win_reg << 4;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (ctrl.pop) begin
            win_next = win_reg << 4;
        end
        if (ctrl.dec) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Hold counters under reset, data registers free-running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
            above_reg   <= 1'b0;
        end else begin
            bit_cnt_reg <= bit_cnt_next;
            cnt_reg     <= cnt_next;
            above_reg   <= above_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        bcd_reg <= bcd_next;
        win_reg <= win_next;
    end

    assign stat.top_digit = top_digit;
    assign stat.conv_done = (bit_cnt_reg == BIT_CNT_W'(NUM_W - 1));
    assign stat.skip_more = skip_more;
    assign stat.cnt_one   = (cnt_reg == CNT_W'(1));

endmodule

FILE: src/char_lcd_nibble_frame_sequencer.sv
`timescale 1ns / 1ps
// First frame: an init request starts with the zero frame; write byte and set cursor load the byte first,
// print integer first runs the bit-serial conversion of all 31 bits, aligns and drops leading zeros.
// Throughput: one frame per cycle within a run of emit steps while m_ready is high; one request at a time,
// the next one taken only once the sequencer is back in its idle step after the final frame is loaded;
// the microcode step counter sets the pace.
// Reset: synchronous, active low; clears the sequencer, empties the output, backlight on.
// ----------------------------------------------------------------------------
// char_lcd_nibble_frame_sequencer
// Microcoded sequencer that turns LCD requests into port-expander frames for
// a 4-bit-mode character controller.
// ----------------------------------------------------------------------------
module char_lcd_nibble_frame_sequencer #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clnfs_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output clnfs_pkg::out_item_t  m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import clnfs_pkg::*;

    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [TBL_IDX_W-1:0] tbl_idx_reg, tbl_idx_next;
    in_item_t             req_reg, req_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 rs_reg, rs_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;
    logic                 backlight_reg;

    ucode_t      uw;
    digit_ctrl_t dctrl;
    digit_stat_t dstat;
    logic        accept;
    logic        out_free;
    logic        emit;
    logic        done;
    logic        jump_taken;
    logic        tbl_last;
    logic        frame_last;
    logic [7:0]  frame;
    logic [7:0]  hi_nib;
    logic [7:0]  lo_nib;

    assign cfg_ready = 1'b1;
    assign s_ready   = (uw.op == OP_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign tbl_last  = (tbl_idx_reg == TBL_IDX_W'(INIT_LEN - 1));

    // Fetch the control word
    always_comb begin
        uw = ucode_rom(pc_reg);
    end

    // Frame assembly
    assign hi_nib = {byte_reg[7:4], 3'b000, rs_reg};
    assign lo_nib = {byte_reg[3:0], 3'b000, rs_reg};

    always_comb begin
        unique case (uw.frame)
            FR_HI:    frame = hi_nib;
            FR_HI_EN: frame = hi_nib | EN_BIT;
            FR_LO:    frame = lo_nib;
            FR_LO_EN: frame = lo_nib | EN_BIT;
            FR_TABLE: frame = INIT_TABLE[tbl_idx_reg];
            default:  frame = 8'h00;
        endcase
    end

    always_comb begin
        unique case (uw.last_sel)
            L_YES:   frame_last = 1'b1;
            L_TABLE: frame_last = tbl_last;
            L_DIGIT: frame_last = dstat.cnt_one;
            default: frame_last = 1'b0;
        endcase
    end

    always_comb begin
        unique case (uw.jump)
            J_ALWAYS:      jump_taken = 1'b1;
            J_MORE_DIGITS: jump_taken = !dstat.cnt_one;
            default:       jump_taken = 1'b0;
        endcase
    end

    // Decode the step: datapath strobes and step completion
    always_comb begin
        dctrl        = '0;
        emit         = 1'b0;
        done         = 1'b0;
        req_next     = req_reg;
        byte_next    = byte_reg;
        rs_next      = rs_reg;
        tbl_idx_next = tbl_idx_reg;
        unique case (uw.op)
            OP_IDLE: begin
                req_next     = s_item;
                tbl_idx_next = '0;
            end
            OP_LOAD_WR: begin
                byte_next = req_reg.byte_value;
                rs_next   = req_reg.is_data;
                done      = 1'b1;
            end
            OP_LOAD_CUR: begin
                byte_next = CURSOR_CMD | {4'h0, req_reg.column}
                            | (req_reg.row ? ROW1_ADDR : 8'h00);
                rs_next   = 1'b0;
                done      = 1'b1;
            end
            OP_CONV_LOAD: begin
                dctrl.load = 1'b1;
                done       = 1'b1;
            end
            OP_CONV: begin
                dctrl.conv = 1'b1;
                done       = dstat.conv_done;
            end
            OP_ALIGN: begin
                dctrl.align = 1'b1;
                done        = 1'b1;
            end
            OP_SKIP: begin
                dctrl.skip = 1'b1;
                done       = !dstat.skip_more;
            end
            OP_LOAD_DIG: begin
                byte_next = {ASCII_HI, dstat.top_digit};
                rs_next   = 1'b1;
                dctrl.pop = 1'b1;
                done      = 1'b1;
            end
            OP_EMIT: begin
                emit = out_free;
                if (out_free && (uw.frame == FR_TABLE)) begin
                    tbl_idx_next = tbl_idx_reg + TBL_IDX_W'(1);
                end
                dctrl.dec = out_free && (uw.last_sel == L_DIGIT);
                done      = out_free && !((uw.frame == FR_TABLE) && !tbl_last);
            end
            default: begin
                done = 1'b1;
            end
        endcase
        if (uw.op != OP_IDLE) begin
            req_next = req_reg;
        end
    end

    // Advance the step counter: dispatch on kind, jump or fall through
    always_comb begin
        pc_next = pc_reg;
        if (uw.op == OP_IDLE) begin
            if (accept) begin
                unique case (s_item.kind)
                    KIND_INIT:   pc_next = PC_INIT;
                    KIND_WRITE:  pc_next = PC_WRITE;
                    KIND_CURSOR: pc_next = PC_CURSOR;
                    KIND_PRINT:  pc_next = PC_PRINT;
                    default:     pc_next = PC_IDLE;
                endcase
            end
        end else if (done) begin
            pc_next = jump_taken ? uw.target : pc_reg + PC_W'(1);
        end
    end

    // Output register: load on emit, drop on transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit) begin
            out_valid_next              = 1'b1;
            out_item_next.expander_byte = frame | (backlight_reg ? BL_BIT : 8'h00);
            out_item_next.last          = frame_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= PC_IDLE;
            tbl_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            backlight_reg <= 1'b1;
        end else begin
            pc_reg        <= pc_next;
            tbl_idx_reg   <= tbl_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                backlight_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        byte_reg     <= byte_next;
        rs_reg       <= rs_next;
        out_item_reg <= out_item_next;
    end

    clnfs_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dctrl),
        .number  (req_reg.number),
        .stat    (dstat)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

FILE: src/clnfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnfs_checker
// Port-level checks for the character-LCD nibble frame sequencer.
// ----------------------------------------------------------------------------
module clnfs_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input clnfs_pkg::out_item_t m_item
);

    // Hold a stalled frame
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled frame changed or dropped");

    // Take no second request straight after a transfer
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one still starting");

    // Come out of reset empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind char_lcd_nibble_frame_sequencer clnfs_checker u_clnfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
